// ===== rtl/imadec_pkg.sv =====
package imadec_pkg;

  localparam int STEP_COUNT  = 89;
  localparam int IDX_MAX     = STEP_COUNT - 1;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CFG_CLAMP_MODE    = 2'd0,
    CFG_NIBBLE_ORDER  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

  // per-channel decoder state as held in the state memory
  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } chan_state_t;

  localparam logic [14:0] STEP_TABLE [STEP_COUNT] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  localparam logic signed [4:0] INDEX_ADJUST [16] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

  localparam logic signed [17:0] PRED_MAX     = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN     = -18'sd32768;
  localparam logic signed [17:0] PRED_MIN_SYM = -18'sd32767;

  // one 4-bit code applied to a channel state
  function automatic chan_state_t decode_nibble(chan_state_t st, logic [3:0] code,
                                                logic sym);
    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] p_ext;
    logic signed [17:0] d_ext;
    logic signed [17:0] p;
    logic signed [17:0] lo;
    logic signed [8:0]  ni;
    chan_state_t        res;
    step  = (st.idx > 7'(IDX_MAX)) ? STEP_TABLE[IDX_MAX] : STEP_TABLE[st.idx];
    diff  = 17'(step >> 3);
    if (code[0]) diff = diff + 17'(step >> 2);
    if (code[1]) diff = diff + 17'(step >> 1);
    if (code[2]) diff = diff + 17'(step);
    p_ext = {{2{st.pred[15]}}, st.pred};
    d_ext = $signed({1'b0, diff});
    p     = code[3] ? (p_ext - d_ext) : (p_ext + d_ext);
    lo    = sym ? PRED_MIN_SYM : PRED_MIN;
    if (p > PRED_MAX)  p = PRED_MAX;
    else if (p < lo)   p = lo;
    res.pred = p[15:0];
    ni = $signed({2'b00, st.idx}) + 9'(INDEX_ADJUST[code]);
    if (ni < 9'sd0)                 res.idx = 7'd0;
    else if (ni > 9'(IDX_MAX))      res.idx = 7'(IDX_MAX);
    else                            res.idx = ni[6:0];
    return res;
  endfunction

endpackage

// ===== rtl/ima_adpcm_channel_decoder.sv =====
// Multi-channel IMA ADPCM decoder, one byte (two 4-bit codes) per input transfer.
// Order: a byte passes s1 and s2 into the output buffer, which offers its first sample;
// the second is offered in the cycle after the first is taken.
// A new byte is taken only once the last one has left s1 and s2 is empty or empties,
// set by the read-decode-decode-write turn on a channel's entry (one code per stage).
// Reset (rst_n low, synchronous): all channels read as predictor 0, step index 0;
// clamp_mode 0, nibble_order 0, channel_count 1; pipeline and output emptied.
module ima_adpcm_channel_decoder #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [2:0] channel, [10:3] data_byte, [11] skip, [27:12] init_predictor,
  // [43:28] init_step_index, [47:44] zero
  input  logic [imadec_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] kind
  input  logic [0:0]                           in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] sample, [18:16] sample_channel, [23:19] zero
  output logic [imadec_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                 out_tlast,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [3:0]                           cfg_data
);
  import imadec_pkg::*;

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ---------------------------------------------------------------------------
  logic       clamp_mode_r;
  logic       nibble_order_r;
  logic [3:0] channel_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_mode_r    <= 1'b0;
      nibble_order_r  <= 1'b0;
      channel_count_r <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLAMP_MODE:    clamp_mode_r    <= cfg_data[0];
        CFG_NIBBLE_ORDER:  nibble_order_r  <= cfg_data[0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input field unpacking
  // ---------------------------------------------------------------------------
  logic [2:0]         in_ch;
  logic [7:0]         in_byte;
  logic               in_skip;
  logic signed [15:0] in_pred;
  logic signed [15:0] in_idx;
  logic               in_xfer;
  logic               in_use;
  logic [AW-1:0]      rd_addr;

  assign in_ch   = in_tdata[2:0];
  assign in_byte = in_tdata[10:3];
  assign in_skip = in_tdata[11];
  assign in_pred = in_tdata[27:12];
  assign in_idx  = in_tdata[43:28];
  assign in_xfer = in_tvalid && in_tready;
  // channels at or above the configured count (or the memory depth) are dropped
  assign in_use  = ({1'b0, in_ch} < channel_count_r) && (32'(in_ch) < MAX_CHANNELS);
  assign rd_addr = AW'(in_ch);

  // ---------------------------------------------------------------------------
  // Stage registers
  // s1: memory read in flight, first code decoded at its end
  // s2: second code decoded, write-back and result hand-off
  // ---------------------------------------------------------------------------
  logic               s1_valid_r;
  kind_t              s1_kind_r;
  logic               s1_use_r;
  logic [2:0]         s1_ch_r;
  logic [7:0]         s1_byte_r;
  logic               s1_skip_r;
  logic signed [15:0] s1_pred_r;
  logic signed [15:0] s1_idx_r;

  logic               s2_valid_r;
  kind_t              s2_kind_r;
  logic               s2_use_r;
  logic               s2_skip_r;
  logic [2:0]         s2_ch_r;
  logic [3:0]         s2_code_r;
  chan_state_t        s2_state_r;

  // ---------------------------------------------------------------------------
  // State memory: one entry per channel, synchronous read.
  // Per-entry valid flags stand in for the all-zero reset.
  // ---------------------------------------------------------------------------
  chan_state_t              mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]  vld_r;
  chan_state_t              rd_q_r;
  logic                     rd_vld_r;
  logic                     byp_r;       // write to the same entry on the read edge
  chan_state_t              byp_data_r;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  chan_state_t              wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q_r     <= mem[rd_addr];
    byp_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= vld_r[rd_addr];
      byp_r    <= wr_en && (wr_addr == rd_addr);
    end
  end

  // ---------------------------------------------------------------------------
  // s1 combinational: pick the current channel state, decode the first code,
  // or clamp the load values.
  // ---------------------------------------------------------------------------
  chan_state_t s1_cur;
  chan_state_t s1_dec;
  chan_state_t s1_load;
  logic [3:0]  s1_first;
  logic [3:0]  s1_second;

  always_comb begin
    if (byp_r)         s1_cur = byp_data_r;
    else if (rd_vld_r) s1_cur = rd_q_r;
    else               s1_cur = '0;

    s1_first  = nibble_order_r ? s1_byte_r[7:4] : s1_byte_r[3:0];
    s1_second = nibble_order_r ? s1_byte_r[3:0] : s1_byte_r[7:4];
    s1_dec    = decode_nibble(s1_cur, s1_first, clamp_mode_r);

    s1_load.pred = (clamp_mode_r && (s1_pred_r == -16'sd32768)) ? -16'sd32767 : s1_pred_r;
    if (s1_idx_r[15])                    s1_load.idx = 7'd0;
    else if (s1_idx_r > 16'(IDX_MAX))    s1_load.idx = 7'(IDX_MAX);
    else                                 s1_load.idx = s1_idx_r[6:0];
  end

  // ---------------------------------------------------------------------------
  // s2 combinational: second code, write-back, hand-off to the output buffer
  // ---------------------------------------------------------------------------
  logic [1:0]         out_cnt_r;
  logic [1:0]         out_cnt_nxt;
  logic signed [15:0] samp0_r;
  logic signed [15:0] samp1_r;
  logic [2:0]         out_ch_r;
  logic               out_xfer;
  chan_state_t        s2_dec;
  logic               s2_emit;
  logic               s2_done;

  assign out_xfer = out_tvalid && out_tready;
  assign s2_dec   = decode_nibble(s2_state_r, s2_code_r, clamp_mode_r);
  assign s2_emit  = s2_use_r && (s2_kind_r == KIND_DATA) && !s2_skip_r;
  // results need the buffer empty, or draining its last sample this cycle
  assign s2_done  = s2_valid_r &&
                    (!s2_emit || (out_cnt_r == 2'd0) || ((out_cnt_r == 2'd1) && out_xfer));

  assign wr_en    = s2_done && s2_use_r;
  assign wr_addr  = AW'(s2_ch_r);
  assign wr_data  = (s2_kind_r == KIND_LOAD) ? s2_state_r : s2_dec;

  // A new item enters only when s1 is empty and s2 is empty or empties this cycle, so an
  // older item's write lands on the new item's read edge and is forwarded.
  assign in_tready = !s1_valid_r && (!s2_valid_r || s2_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
      if (s1_valid_r)   s2_valid_r <= 1'b1;
      else if (s2_done) s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= kind_t'(in_tuser[0]);
      s1_use_r  <= in_use;
      s1_ch_r   <= in_ch;
      s1_byte_r <= in_byte;
      s1_skip_r <= in_skip;
      s1_pred_r <= in_pred;
      s1_idx_r  <= in_idx;
    end
    if (s1_valid_r) begin
      s2_kind_r  <= s1_kind_r;
      s2_use_r   <= s1_use_r;
      s2_skip_r  <= s1_skip_r;
      s2_ch_r    <= s1_ch_r;
      s2_code_r  <= s1_second;
      s2_state_r <= (s1_kind_r == KIND_LOAD) ? s1_load : s1_dec;
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer: holds both samples of a byte; count 2 shows the first,
  // count 1 the second (tlast).
  // ---------------------------------------------------------------------------
  always_comb begin
    priority if (s2_done && s2_emit) out_cnt_nxt = 2'd2;
    else if (out_xfer)               out_cnt_nxt = out_cnt_r - 2'd1;
    else                             out_cnt_nxt = out_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_cnt_r <= 2'd0;
    else        out_cnt_r <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (s2_done && s2_emit) begin
      samp0_r  <= s2_state_r.pred;
      samp1_r  <= s2_dec.pred;
      out_ch_r <= s2_ch_r;
    end
  end

  assign out_tvalid = (out_cnt_r != 2'd0);
  assign out_tlast  = (out_cnt_r == 2'd1);
  assign out_tdata  = {5'd0, out_ch_r, (out_tlast ? samp1_r : samp0_r)};

endmodule
